[hdl/pte_pkg.sv]
// ----------------------------------------------------------------------------
// pte_pkg
// Shared types, register codes and arithmetic helpers for the polygon
// edge plane block.
// ----------------------------------------------------------------------------
package pte_pkg;

  typedef logic signed [31:0] coord_t;  // Q16.16
  typedef logic signed [15:0] norm_t;   // Q1.14
  typedef logic        [1:0]  cfg_addr_t;

  typedef enum logic [1:0] {
    REG_ROTATION = 2'd0,
    REG_OFFSET_X = 2'd1,
    REG_OFFSET_Y = 2'd2
  } cfg_reg_e;

  // CORDIC gain compensation, Q2.30
  localparam logic signed [33:0] CORDIC_K = 34'sd652032874;
  localparam int unsigned        ATAN_COUNT = 24;

  // atan(2^-i) as a fraction of a turn, 2^32 = one turn
  function automatic logic signed [33:0] atan_turn(input logic [4:0] idx);
    logic signed [33:0] v;
    case (idx)
      5'd0:    v = 34'sh20000000;
      5'd1:    v = 34'sh12E4051D;
      5'd2:    v = 34'sh09FB385B;
      5'd3:    v = 34'sh051111D4;
      5'd4:    v = 34'sh028B0D43;
      5'd5:    v = 34'sh0145D7E1;
      5'd6:    v = 34'sh00A2F61E;
      5'd7:    v = 34'sh00517C55;
      5'd8:    v = 34'sh0028BE53;
      5'd9:    v = 34'sh00145F2E;
      5'd10:   v = 34'sh000A2F98;
      5'd11:   v = 34'sh000517CC;
      5'd12:   v = 34'sh00028BE6;
      5'd13:   v = 34'sh000145F3;
      5'd14:   v = 34'sh0000A2F9;
      5'd15:   v = 34'sh0000517C;
      5'd16:   v = 34'sh000028BE;
      5'd17:   v = 34'sh0000145F;
      5'd18:   v = 34'sh00000A2F;
      5'd19:   v = 34'sh00000517;
      5'd20:   v = 34'sh0000028B;
      5'd21:   v = 34'sh00000145;
      5'd22:   v = 34'sh000000A2;
      5'd23:   v = 34'sh00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

  // clamp a wide signed value to 32 bits
  function automatic coord_t sat32(input logic signed [65:0] v);
    coord_t r;
    if (v > 66'sh7FFFFFFF) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -66'sh80000000) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[hdl/pte_if.sv]
// ----------------------------------------------------------------------------
// pte_if
// Channel interfaces: vertex input, edge result output, register write.
// ----------------------------------------------------------------------------
interface pte_vtx_if;
  logic            valid;
  logic            ready;
  pte_pkg::coord_t local_x;
  pte_pkg::coord_t local_y;
  logic            final_vertex;

  modport source (output valid, local_x, local_y, final_vertex, input ready);
  modport sink   (input valid, local_x, local_y, final_vertex, output ready);
endinterface

interface pte_edge_if;
  logic            valid;
  logic            ready;
  pte_pkg::coord_t world_x;
  pte_pkg::coord_t world_y;
  pte_pkg::norm_t  normal_x;
  pte_pkg::norm_t  normal_y;
  pte_pkg::coord_t plane_dist;
  logic            zero_edge;
  logic            polygon_done;

  modport source (output valid, world_x, world_y, normal_x, normal_y, plane_dist,
                  zero_edge, polygon_done, input ready);
  modport sink   (input valid, world_x, world_y, normal_x, normal_y, plane_dist,
                  zero_edge, polygon_done, output ready);
endinterface

interface pte_cfg_if;
  logic                 valid;
  logic                 ready;
  pte_pkg::cfg_addr_t   addr;
  logic          [31:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

[hdl/polygon_transform_edge_planes.sv]
// ----------------------------------------------------------------------------
// polygon_transform_edge_planes
// Rotates and translates polygon vertices and emits one edge plane
// (start vertex, unit normal, plane distance) per edge.
// ----------------------------------------------------------------------------
// One vertex request is taken at a time; vtx_i.ready is high only while the
// sequencer is idle. A vertex runs TRIG_ITERATIONS CORDIC steps, the quadrant
// fold and multiply/accumulate of the transform and a store. Each edge then
// passes an abs step, up to 29 normalize shifts and a check, the squaring, 32
// square root steps, two divisions of one load and 15 steps each, a sign step,
// the distance products and the output; a zero-length edge goes from the check
// to the output. A vertex that closes the polygon produces its edge and
// the closing edge (set up in S_CLOSE), or only the latter if first; any
// other first vertex produces none. All multiplies go through one 32x32 signed
// multiplier, registered; the square root and divisions are bit-serial, the
// divisions sharing one remainder path. A result waits in the output register
// until taken; the sequencer waits in S_OUT while it is full and not taken.
// Registers may be written only while idle; cfg_i.ready is always high.
// A zero-length edge reports zero normal and distance with zero_edge set.
module polygon_transform_edge_planes #(
  parameter int unsigned TRIG_ITERATIONS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pte_cfg_if.sink     cfg_i,
  pte_vtx_if.sink     vtx_i,
  pte_edge_if.source  edge_o
);
  import pte_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_TRIG  = 4'd1;
  localparam logic [3:0] S_XFORM = 4'd2;
  localparam logic [3:0] S_WORLD = 4'd3;
  localparam logic [3:0] S_CLOSE = 4'd4;
  localparam logic [3:0] S_ABS   = 4'd5;
  localparam logic [3:0] S_NORM  = 4'd6;
  localparam logic [3:0] S_SQ    = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_DIVI  = 4'd9;
  localparam logic [3:0] S_DIV   = 4'd10;
  localparam logic [3:0] S_SIGN  = 4'd11;
  localparam logic [3:0] S_DIST  = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  localparam logic [4:0] TRIG_LAST = 5'(TRIG_ITERATIONS - 1);

  logic [3:0] state_q;
  logic [4:0] cnt_q;

  // configuration
  logic [15:0] rot_q;
  coord_t      off_x_q, off_y_q;

  // vertex and polygon state
  coord_t lx_q, ly_q;
  logic   fin_q;
  coord_t first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic   have_prev_q;
  logic   pend_close_q;
  coord_t wx_q, wy_q;

  // CORDIC
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic        [1:0]  quad_q;
  coord_t             cos_q, sin_q;

  // shared multiplier and accumulator
  coord_t             mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] prod_q;
  logic signed [65:0] acc_q;

  // current edge
  coord_t      fx_q, fy_q, tx_q, ty_q;
  logic        done_q;
  logic [32:0] ax_q, ay_q;
  logic        ex_neg_q, ey_pos_q;

  // square root and division
  logic [63:0] sq_n_q, sq_res_q, sq_bit_q;
  logic [45:0] rem_q, den_q;
  logic [14:0] quo_q;
  logic        div_sel_q;
  logic [14:0] mx_q, my_q;
  norm_t       nx_q, ny_q;
  coord_t      dist_q;
  logic        zero_q;

  // output register
  logic   out_valid_q;
  coord_t o_wx_q, o_wy_q, o_dist_q;
  norm_t  o_nx_q, o_ny_q;
  logic   o_zero_q, o_done_q;

  // ---- combinational helpers ----
  logic        [16:0] ang_round;
  logic        [1:0]  quad_sel;
  logic        [31:0] z_init;
  logic signed [33:0] cx_sh, cy_sh, atan_v;
  logic signed [32:0] ex_w, ey_w;
  logic        [32:0] m_max;
  logic        [63:0] sq_trial;
  logic        [31:0] len_w;
  logic        [14:0] quo_next;
  logic signed [65:0] wsum;
  logic               out_free;

  assign ang_round = {1'b0, rot_q} + 17'h2000;
  assign quad_sel  = ang_round[15:14];
  assign z_init    = {rot_q, 16'h0000} - {quad_sel, 30'd0};
  assign cx_sh     = cx_q >>> cnt_q;
  assign cy_sh     = cy_q >>> cnt_q;
  assign atan_v    = atan_turn(cnt_q);
  assign ex_w      = 33'(tx_q) - 33'(fx_q);
  assign ey_w      = 33'(ty_q) - 33'(fy_q);
  assign m_max     = (ax_q > ay_q) ? ax_q : ay_q;
  assign sq_trial  = sq_res_q + sq_bit_q;
  assign len_w     = sq_res_q[31:0];
  assign quo_next  = {quo_q[13:0], (rem_q >= den_q)};
  assign out_free  = !out_valid_q || edge_o.ready;

  always_comb begin
    mul_a = lx_q;
    mul_b = cos_q;
    case (state_q)
      S_XFORM: begin
        // cos/sin are folded at count 0, products start at count 1
        case (cnt_q)
          5'd2:    begin mul_a = ly_q; mul_b = sin_q; end
          5'd3:    begin mul_a = lx_q; mul_b = sin_q; end
          5'd4:    begin mul_a = ly_q; mul_b = cos_q; end
          default: begin mul_a = lx_q; mul_b = cos_q; end
        endcase
      end
      S_SQ: begin
        if (cnt_q == 5'd0) begin
          mul_a = coord_t'({2'b00, ax_q[29:0]});
          mul_b = coord_t'({2'b00, ax_q[29:0]});
        end else begin
          mul_a = coord_t'({2'b00, ay_q[29:0]});
          mul_b = coord_t'({2'b00, ay_q[29:0]});
        end
      end
      S_DIST: begin
        if (cnt_q == 5'd0) begin
          mul_a = fx_q;
          mul_b = 32'(nx_q);
        end else begin
          mul_a = fy_q;
          mul_b = 32'(ny_q);
        end
      end
      default: begin
        mul_a = lx_q;
        mul_b = cos_q;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign wsum  = (acc_q >>> 30) + 66'(((state_q == S_XFORM) && (cnt_q == 5'd4)) ?
                                      off_x_q : off_y_q);

  // ---- sequencer and datapath ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      rot_q        <= '0;
      off_x_q      <= '0;
      off_y_q      <= '0;
      have_prev_q  <= 1'b0;
      pend_close_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.addr)
          REG_ROTATION: rot_q   <= cfg_i.data[15:0];
          REG_OFFSET_X: off_x_q <= cfg_i.data;
          REG_OFFSET_Y: off_y_q <= cfg_i.data;
          default:      ;
        endcase
      end

      if (out_valid_q && edge_o.ready) begin
        out_valid_q <= 1'b0;
      end

      prod_q <= mul_p;

      case (state_q)
        S_IDLE: begin
          if (vtx_i.valid) begin
            lx_q    <= vtx_i.local_x;
            ly_q    <= vtx_i.local_y;
            fin_q   <= vtx_i.final_vertex;
            quad_q  <= quad_sel;
            cx_q    <= CORDIC_K;
            cy_q    <= '0;
            cz_q    <= 34'(signed'(z_init));
            cnt_q   <= '0;
            state_q <= S_TRIG;
          end
        end

        S_TRIG: begin
          if (cz_q >= 0) begin
            cx_q <= cx_q - cy_sh;
            cy_q <= cy_q + cx_sh;
            cz_q <= cz_q - atan_v;
          end else begin
            cx_q <= cx_q + cy_sh;
            cy_q <= cy_q - cx_sh;
            cz_q <= cz_q + atan_v;
          end
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == TRIG_LAST) begin
            cnt_q   <= '0;
            state_q <= S_XFORM;
          end
        end

        S_XFORM: begin
          // quadrant fold of the CORDIC result
          if (cnt_q == 5'd0) begin
            case (quad_q)
              2'd1:    begin cos_q <= 32'(-cy_q); sin_q <= 32'(cx_q);  end
              2'd2:    begin cos_q <= 32'(-cx_q); sin_q <= 32'(-cy_q); end
              2'd3:    begin cos_q <= 32'(cy_q);  sin_q <= 32'(-cx_q); end
              default: begin cos_q <= 32'(cx_q);  sin_q <= 32'(cy_q);  end
            endcase
          end
          case (cnt_q)
            5'd2: acc_q <= 66'(prod_q);
            5'd3: acc_q <= acc_q - 66'(prod_q) + 66'sd536870912;
            5'd4: begin
              wx_q  <= sat32(wsum);
              acc_q <= 66'(prod_q);
            end
            5'd5: acc_q <= acc_q + 66'(prod_q) + 66'sd536870912;
            5'd6: begin
              wy_q    <= sat32(wsum);
              state_q <= S_WORLD;
            end
            default: ;
          endcase
          cnt_q <= cnt_q + 5'd1;
        end

        S_WORLD: begin
          prev_x_q    <= wx_q;
          prev_y_q    <= wy_q;
          have_prev_q <= 1'b1;
          cnt_q       <= '0;
          if (!have_prev_q) begin
            first_x_q <= wx_q;
            first_y_q <= wy_q;
            state_q   <= fin_q ? S_CLOSE : S_IDLE;
          end else begin
            fx_q         <= prev_x_q;
            fy_q         <= prev_y_q;
            tx_q         <= wx_q;
            ty_q         <= wy_q;
            done_q       <= 1'b0;
            pend_close_q <= fin_q;
            state_q      <= S_ABS;
          end
        end

        S_CLOSE: begin
          fx_q         <= wx_q;
          fy_q         <= wy_q;
          tx_q         <= first_x_q;
          ty_q         <= first_y_q;
          done_q       <= 1'b1;
          pend_close_q <= 1'b0;
          have_prev_q  <= 1'b0;
          state_q      <= S_ABS;
        end

        S_ABS: begin
          ax_q     <= ex_w[32] ? 33'(-ex_w) : 33'(ex_w);
          ay_q     <= ey_w[32] ? 33'(-ey_w) : 33'(ey_w);
          ex_neg_q <= ex_w[32];
          ey_pos_q <= !ey_w[32] && (ey_w != 33'sd0);
          state_q  <= S_NORM;
        end

        S_NORM: begin
          cnt_q <= '0;
          if (m_max == 33'd0) begin
            nx_q    <= '0;
            ny_q    <= '0;
            dist_q  <= '0;
            zero_q  <= 1'b1;
            state_q <= S_OUT;
          end else if (m_max[32:30] != 3'd0) begin
            ax_q <= ax_q >> 1;
            ay_q <= ay_q >> 1;
          end else if (!m_max[29]) begin
            ax_q <= ax_q << 1;
            ay_q <= ay_q << 1;
          end else begin
            zero_q  <= 1'b0;
            state_q <= S_SQ;
          end
        end

        S_SQ: begin
          cnt_q <= cnt_q + 5'd1;
          case (cnt_q)
            5'd1: acc_q <= 66'(prod_q);
            5'd2: acc_q <= acc_q + 66'(prod_q);
            5'd3: begin
              sq_n_q   <= acc_q[63:0];
              sq_res_q <= '0;
              sq_bit_q <= 64'h4000_0000_0000_0000;
              cnt_q    <= '0;
              state_q  <= S_SQRT;
            end
            default: ;
          endcase
        end

        S_SQRT: begin
          if (sq_n_q >= sq_trial) begin
            sq_n_q   <= sq_n_q - sq_trial;
            sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
          end else begin
            sq_res_q <= sq_res_q >> 1;
          end
          sq_bit_q <= sq_bit_q >> 2;
          cnt_q    <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            div_sel_q <= 1'b0;
            state_q   <= S_DIVI;
          end
        end

        S_DIVI: begin
          // numerator is the other component scaled by 2^14, rounded
          rem_q   <= {2'b00, (div_sel_q ? ax_q[29:0] : ay_q[29:0]), 14'd0} +
                     {15'd0, len_w[31:1]};
          den_q   <= {len_w[31:0], 14'd0};
          quo_q   <= '0;
          cnt_q   <= '0;
          state_q <= S_DIV;
        end

        S_DIV: begin
          if (rem_q >= den_q) begin
            rem_q <= rem_q - den_q;
          end
          den_q <= den_q >> 1;
          quo_q <= quo_next;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd14) begin
            cnt_q <= '0;
            if (!div_sel_q) begin
              mx_q      <= quo_next;
              div_sel_q <= 1'b1;
              state_q   <= S_DIVI;
            end else begin
              my_q    <= quo_next;
              state_q <= S_SIGN;
            end
          end
        end

        S_SIGN: begin
          nx_q    <= ey_pos_q ? -norm_t'({1'b0, mx_q}) : norm_t'({1'b0, mx_q});
          ny_q    <= ex_neg_q ? -norm_t'({1'b0, my_q}) : norm_t'({1'b0, my_q});
          cnt_q   <= '0;
          state_q <= S_DIST;
        end

        S_DIST: begin
          cnt_q <= cnt_q + 5'd1;
          case (cnt_q)
            5'd1: acc_q <= 66'(prod_q);
            5'd2: acc_q <= acc_q + 66'(prod_q) + 66'sd8192;
            5'd3: begin
              dist_q  <= sat32(acc_q >>> 14);
              state_q <= S_OUT;
            end
            default: ;
          endcase
        end

        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            o_wx_q      <= fx_q;
            o_wy_q      <= fy_q;
            o_nx_q      <= nx_q;
            o_ny_q      <= ny_q;
            o_dist_q    <= dist_q;
            o_zero_q    <= zero_q;
            o_done_q    <= done_q;
            state_q     <= pend_close_q ? S_CLOSE : S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign vtx_i.ready = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign edge_o.valid        = out_valid_q;
  assign edge_o.world_x      = o_wx_q;
  assign edge_o.world_y      = o_wy_q;
  assign edge_o.normal_x     = o_nx_q;
  assign edge_o.normal_y     = o_ny_q;
  assign edge_o.plane_dist   = o_dist_q;
  assign edge_o.zero_edge    = o_zero_q;
  assign edge_o.polygon_done = o_done_q;

endmodule

[hdl/pte_checker.sv]
// ----------------------------------------------------------------------------
// pte_checker
// Port-level checks for the polygon edge plane block, bound to the top.
// ----------------------------------------------------------------------------
module pte_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               vtx_valid_i,
  input logic               vtx_ready_i,
  input logic               edge_valid_i,
  input logic               edge_ready_i,
  input logic signed [31:0] world_x_i,
  input logic signed [15:0] normal_x_i,
  input logic signed [15:0] normal_y_i,
  input logic signed [31:0] plane_dist_i,
  input logic               zero_edge_i
);

  // ready is low in the cycle after a vertex is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vtx_valid_i && vtx_ready_i) |=> !vtx_ready_i)
    else $error("vertex ready right after a request");

  // zero edge carries zero normal and distance
  a_zero_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (edge_valid_i && zero_edge_i) |->
      (normal_x_i == 16'sd0 && normal_y_i == 16'sd0 && plane_dist_i == 32'sd0))
    else $error("zero edge with nonzero plane");

  // normal components stay within unit range
  a_norm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    edge_valid_i |-> (normal_x_i <= 16'sd16384 && normal_x_i >= -16'sd16384 &&
                      normal_y_i <= 16'sd16384 && normal_y_i >= -16'sd16384))
    else $error("normal out of range");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (edge_valid_i && !edge_ready_i) |=> (edge_valid_i && $stable(world_x_i)))
    else $error("stalled result dropped or changed");

endmodule

bind polygon_transform_edge_planes pte_checker u_pte_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .vtx_valid_i  (vtx_i.valid),
  .vtx_ready_i  (vtx_i.ready),
  .edge_valid_i (edge_o.valid),
  .edge_ready_i (edge_o.ready),
  .world_x_i    (edge_o.world_x),
  .normal_x_i   (edge_o.normal_x),
  .normal_y_i   (edge_o.normal_y),
  .plane_dist_i (edge_o.plane_dist),
  .zero_edge_i  (edge_o.zero_edge)
);
